[rtl/beg_pkg.sv]
// Shared types and constants for the breakpoint envelope gain unit.
// Holds item opcodes, register indexes and stream field layouts.
// No dependencies.
package beg_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } beg_op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_POINTS   = 2'd0,
    CFG_CLIP     = 2'd1,
    CFG_CHANNELS = 2'd2
  } beg_cfg_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Field widths
  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int SLOT_W   = 3;
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 16;
  localparam int OUT_W    = 21;

  // Input tdata layout: sample_in, point_slot, point_frame, point_level
  localparam int S_SAMPLE_LSB = 0;
  localparam int S_SLOT_LSB   = S_SAMPLE_LSB + SAMPLE_W;
  localparam int S_TIME_LSB   = S_SLOT_LSB + SLOT_W;
  localparam int S_LEVEL_LSB  = S_TIME_LSB + TIME_W;
  localparam int S_USED_W     = S_LEVEL_LSB + LEVEL_W;
  localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

  // Output tdata layout: sample_out, gain_applied
  localparam int M_SAMPLE_LSB = 0;
  localparam int M_GAIN_LSB   = M_SAMPLE_LSB + OUT_W;
  localparam int M_USED_W     = M_GAIN_LSB + LEVEL_W;
  localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

  // Interpolation divider: quotient magnitude stays below 2^16
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = 4;

  // Scaling: rounding bias for the Q4.12 gain and the clip limits
  localparam int GAIN_FRAC = 12;
  localparam logic signed [OUT_W-1:0] CLIP_HI = 21'sd32768;
  localparam logic signed [OUT_W-1:0] CLIP_LO = -21'sd32768;

endpackage

[rtl/breakpoint_envelope_gain_unit.sv]
// Breakpoint envelope gain unit: piecewise linear gain applied to
// interleaved audio frames; uses beg_pkg for codes and field layouts.
// A sample that is not the first channel of a frame passes through the scale
// and round states to the output register. The first channel of a frame first
// walks the breakpoints passed through the single table read port, one entry at
// a time, and may then use the 16-step shared divider to interpolate.
// One item at a time; write and restart items finish in the accept cycle.
// Reset (rst_ni low, asynchronous) clears position, gain, config and control.
module breakpoint_envelope_gain_unit #(
  parameter int MAX_POINTS   = 8,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [beg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [beg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_in[15:0], point_slot[18:16], point_frame[50:19], point_level[66:51]
  input  logic [beg_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  logic [beg_pkg::OP_W-1:0]      s_axis_tuser,
  // Result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample_out[20:0], gain_applied[36:21]
  output logic [beg_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import beg_pkg::*;

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int PCMP_W = (PCNT_W > CFG_DATA_W) ? PCNT_W : CFG_DATA_W;
  localparam int CCNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CCMP_W = (CCNT_W > CFG_DATA_W) ? CCNT_W : CFG_DATA_W;
  localparam int CPOS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ENTRY_W = TIME_W + LEVEL_W;
  localparam int ALU_W  = TIME_W + 1;
  localparam int MULA_W = TIME_W + 1;
  localparam int MULB_W = LEVEL_W + 1;
  localparam int PROD_W = MULA_W + MULB_W;
  localparam int SPROD_W = SAMPLE_W + LEVEL_W;

  // Sequencer state codes
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ADV_RD    = 4'd1;
  localparam logic [3:0] ST_ADV_CMP   = 4'd2;
  localparam logic [3:0] ST_GAIN_LAST = 4'd3;
  localparam logic [3:0] ST_P0_CHK    = 4'd4;
  localparam logic [3:0] ST_SEG0      = 4'd5;
  localparam logic [3:0] ST_SEG1      = 4'd6;
  localparam logic [3:0] ST_DELTA     = 4'd7;
  localparam logic [3:0] ST_MUL       = 4'd8;
  localparam logic [3:0] ST_DIV       = 4'd9;
  localparam logic [3:0] ST_SCALE     = 4'd10;
  localparam logic [3:0] ST_ROUND     = 4'd11;

  // Configuration registers
  logic [CFG_DATA_W-1:0] points_q, channels_q;
  logic                  clip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q   <= CFG_DATA_W'(2);
      clip_q     <= 1'b0;
      channels_q <= CFG_DATA_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POINTS:   points_q   <= cfg_data_i;
        CFG_CLIP:     clip_q     <= cfg_data_i[0];
        CFG_CHANNELS: channels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate counts to the supported ranges
  logic [PCMP_W-1:0] npts;
  logic [CCMP_W-1:0] nch;
  logic [PIDX_W-1:0] last_idx;

  always_comb begin
    npts = PCMP_W'(points_q);
    if (npts < PCMP_W'(2)) npts = PCMP_W'(2);
    if (npts > PCMP_W'(MAX_POINTS)) npts = PCMP_W'(MAX_POINTS);
    nch = CCMP_W'(channels_q);
    if (nch < CCMP_W'(1)) nch = CCMP_W'(1);
    if (nch > CCMP_W'(MAX_CHANNELS)) nch = CCMP_W'(MAX_CHANNELS);
  end

  assign last_idx = PIDX_W'(npts - PCMP_W'(1));

  // Input field unpacking
  logic [OP_W-1:0]     in_op;
  logic [SAMPLE_W-1:0] in_sample;
  logic [SLOT_W-1:0]   in_slot;
  logic [TIME_W-1:0]   in_time;
  logic [LEVEL_W-1:0]  in_level;

  assign in_op     = s_axis_tuser;
  assign in_sample = s_axis_tdata[S_SAMPLE_LSB +: SAMPLE_W];
  assign in_slot   = s_axis_tdata[S_SLOT_LSB +: SLOT_W];
  assign in_time   = s_axis_tdata[S_TIME_LSB +: TIME_W];
  assign in_level  = s_axis_tdata[S_LEVEL_LSB +: LEVEL_W];

  // Control and datapath registers
  logic [3:0]          state_q, state_d;
  logic [TIME_W-1:0]   frame_q, frame_d;
  logic [PIDX_W-1:0]   seg_q, seg_d;
  logic [CPOS_W-1:0]   pos_q, pos_d;
  logic [LEVEL_W-1:0]  gain_q, gain_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [TIME_W-1:0]   t0_q, t0_d;
  logic [LEVEL_W-1:0]  v0_q, v0_d;
  logic [TIME_W-1:0]   span_q, span_d;
  logic [TIME_W-1:0]   delta_q, delta_d;
  logic                dneg_q, dneg_d;
  logic [LEVEL_W-1:0]  dmag_q, dmag_d;
  logic [TIME_W-1:0]   rem_q, rem_d;
  logic [LEVEL_W-1:0]  quo_q, quo_d;
  logic [SPROD_W-1:0]  prod_q, prod_d;
  logic                out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  // Breakpoint table: one write port, one registered read port
  logic [ENTRY_W-1:0] table_mem [MAX_POINTS];
  logic [ENTRY_W-1:0] rd_q;
  logic [PIDX_W-1:0]  rd_addr;
  logic               wr_en;
  logic [TIME_W-1:0]  rd_time;
  logic [LEVEL_W-1:0] rd_level;

  assign rd_time  = rd_q[LEVEL_W +: TIME_W];
  assign rd_level = rd_q[0 +: LEVEL_W];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[PIDX_W'(in_slot)] <= {in_time, in_level};
    end
    rd_q <= table_mem[rd_addr];
  end

  // Shared subtractor: compares, spans, offsets and divide steps
  logic [ALU_W-1:0] alu_a, alu_b;
  logic [ALU_W:0]   alu_diff;
  logic             alu_borrow;

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[ALU_W];

  // Shared multiplier: interpolation product and sample scaling
  logic signed [MULA_W-1:0] mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_out;

  assign mul_out = mul_a * mul_b;

  // Level difference of the current segment
  logic [LEVEL_W:0]   lvl_diff;
  logic [LEVEL_W-1:0] q_next;

  assign lvl_diff = {1'b0, rd_level} - {1'b0, v0_q};
  assign q_next   = {quo_q[LEVEL_W-2:0], ~alu_borrow};

  // Rounding and clipping of the scaled sample
  logic [SPROD_W:0]         round_sum;
  logic signed [OUT_W-1:0]  scaled;
  logic signed [OUT_W-1:0]  clipped;
  logic [CCMP_W-1:0]        pos_inc;

  assign round_sum = {prod_q[SPROD_W-1], prod_q} + (SPROD_W+1)'(1 << (GAIN_FRAC - 1));
  assign scaled    = round_sum[GAIN_FRAC +: OUT_W];
  assign pos_inc   = CCMP_W'(pos_q) + CCMP_W'(1);

  always_comb begin
    clipped = scaled;
    if (clip_q) begin
      if (scaled > CLIP_HI) clipped = CLIP_HI;
      if (scaled < CLIP_LO) clipped = CLIP_LO;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    seg_d       = seg_q;
    pos_d       = pos_q;
    gain_d      = gain_q;
    cnt_d       = cnt_q;
    sample_d    = sample_q;
    t0_d        = t0_q;
    v0_d        = v0_q;
    span_d      = span_q;
    delta_d     = delta_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_addr     = seg_q;
    wr_en       = 1'b0;
    alu_a       = {1'b0, frame_q};
    alu_b       = {1'b0, rd_time};
    mul_a       = MULA_W'($signed(sample_q));
    mul_b       = $signed({1'b0, gain_q});

    // Drop the result once taken downstream
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_op)
            OP_SAMPLE: begin
              sample_d = in_sample;
              state_d  = (pos_q == '0) ? ST_ADV_RD : ST_SCALE;
            end
            OP_WRITE: begin
              wr_en = (32'(in_slot) < MAX_POINTS);
            end
            OP_RESTART: begin
              frame_d = '0;
              seg_d   = '0;
              pos_d   = '0;
            end
            default: ;
          endcase
        end
      end
      // Walk the segment index past reached breakpoints
      ST_ADV_RD: begin
        if (seg_q < last_idx) begin
          rd_addr = seg_q + PIDX_W'(1);
          state_d = ST_ADV_CMP;
        end else begin
          rd_addr = last_idx;
          state_d = ST_GAIN_LAST;
        end
      end
      ST_ADV_CMP: begin
        alu_a = {1'b0, frame_q};
        alu_b = {1'b0, rd_time};
        if (!alu_borrow) begin
          seg_d   = seg_q + PIDX_W'(1);
          state_d = ST_ADV_RD;
        end else begin
          rd_addr = '0;
          state_d = ST_P0_CHK;
        end
      end
      ST_GAIN_LAST: begin
        gain_d  = rd_level;
        state_d = ST_SCALE;
      end
      // Hold the first level up to the first breakpoint
      ST_P0_CHK: begin
        alu_a = {1'b0, rd_time};
        alu_b = {1'b0, frame_q};
        if (!alu_borrow) begin
          gain_d  = rd_level;
          state_d = ST_SCALE;
        end else begin
          rd_addr = seg_q;
          state_d = ST_SEG0;
        end
      end
      ST_SEG0: begin
        t0_d    = rd_time;
        v0_d    = rd_level;
        rd_addr = seg_q + PIDX_W'(1);
        state_d = ST_SEG1;
      end
      // Span of the segment; an empty or reversed span holds the start level
      ST_SEG1: begin
        alu_a = {1'b0, rd_time};
        alu_b = {1'b0, t0_q};
        if (alu_borrow || (alu_diff == '0)) begin
          gain_d  = v0_q;
          state_d = ST_SCALE;
        end else begin
          span_d  = alu_diff[TIME_W-1:0];
          dneg_d  = lvl_diff[LEVEL_W];
          dmag_d  = lvl_diff[LEVEL_W] ? LEVEL_W'(-lvl_diff) : lvl_diff[LEVEL_W-1:0];
          state_d = ST_DELTA;
        end
      end
      // Offset into the segment; a frame before its start holds the start level
      ST_DELTA: begin
        alu_a = {1'b0, frame_q};
        alu_b = {1'b0, t0_q};
        if (alu_borrow) begin
          gain_d  = v0_q;
          state_d = ST_SCALE;
        end else begin
          delta_d = alu_diff[TIME_W-1:0];
          state_d = ST_MUL;
        end
      end
      // Product of offset and level step, loaded into the divider
      ST_MUL: begin
        mul_a   = $signed({1'b0, delta_q});
        mul_b   = $signed({1'b0, dmag_q});
        rem_d   = mul_out[LEVEL_W +: TIME_W];
        quo_d   = mul_out[LEVEL_W-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      // Restoring division, one quotient bit per cycle
      ST_DIV: begin
        alu_a = {rem_q, quo_q[LEVEL_W-1]};
        alu_b = {1'b0, span_q};
        rem_d = alu_borrow ? alu_a[TIME_W-1:0] : alu_diff[TIME_W-1:0];
        quo_d = q_next;
        cnt_d = cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          gain_d  = dneg_q ? (v0_q - q_next) : (v0_q + q_next);
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_d  = mul_out[SPROD_W-1:0];
        state_d = ST_ROUND;
      end
      // Issue the result and advance the channel position, and the frame after the last channel
      ST_ROUND: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[M_SAMPLE_LSB +: OUT_W] = clipped;
          out_data_d[M_GAIN_LSB +: LEVEL_W] = gain_q;
          if (pos_inc >= nch) begin
            pos_d   = '0;
            frame_d = frame_q + TIME_W'(1);
          end else begin
            pos_d = CPOS_W'(pos_inc);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_q     <= '0;
      seg_q       <= '0;
      pos_q       <= '0;
      gain_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      seg_q       <= seg_d;
      pos_q       <= pos_d;
      gain_q      <= gain_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    t0_q       <= t0_d;
    v0_q       <= v0_d;
    span_q     <= span_d;
    delta_q    <= delta_d;
    dneg_q     <= dneg_d;
    dmag_q     <= dmag_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

endmodule

[rtl/beg_checker.sv]
// Port-level checks for the breakpoint envelope gain unit.
// Depends on beg_pkg; bound to breakpoint_envelope_gain_unit below.
module beg_assert_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [beg_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [beg_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import beg_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A sample item occupies the block for at least the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == OP_SAMPLE) |=> !s_axis_tready)
    else $error("input ready right after a sample item");

  // Write, restart and unused items never start a result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser != OP_SAMPLE) |=> !$rose(m_axis_tvalid))
    else $error("result appeared after a non-sample item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:M_USED_W] == '0))
    else $error("result padding not zero");

endmodule

bind breakpoint_envelope_gain_unit beg_assert_checker u_beg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
